// ===== hdl/tcc_pkg.sv =====
`timescale 1ns / 1ps

package tcc_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int TERM_COUNT    = 4;

  localparam int CELLS      = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int SAVE_CELLS = TERM_COUNT * CELLS;
  localparam int SCR_AW     = $clog2(CELLS);
  localparam int SAV_AW     = $clog2(SAVE_CELLS);
  localparam int TERM_IW    = (TERM_COUNT > 1) ? $clog2(TERM_COUNT) : 1;

  localparam int OP_W    = 3;
  localparam int CHAR_W  = 8;
  localparam int STEP_W  = 2;
  localparam int TGT_W   = 4;
  localparam int COLOR_W = 8;
  localparam int ADDR_W  = 11;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int OFF_W   = 11;
  localparam int ACT_W   = 2;
  localparam int CELL_W  = 16;

  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR  = 8'h0A;
  localparam logic [CHAR_W-1:0]  BLANK_CHAR    = 8'h20;
  localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 8'h0F;

  typedef enum logic [OP_W-1:0] {
    OP_PUT         = 3'd0,
    OP_MOVE        = 3'd1,
    OP_SWITCH      = 3'd2,
    OP_SET_COLOR   = 3'd3,
    OP_RESET_COLOR = 3'd4,
    OP_READ        = 3'd5
  } tcc_op_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             scroll;
  } tcc_move_t;

  typedef struct packed {
    logic              we;
    logic [SCR_AW-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [SCR_AW-1:0] raddr;
  } tcc_scr_req_t;

  typedef struct packed {
    logic              we;
    logic [SAV_AW-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [SAV_AW-1:0] raddr;
  } tcc_sav_req_t;

endpackage

// ===== hdl/tcc_if.sv =====
`timescale 1ns / 1ps

interface tcc_in_if import tcc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [CHAR_W-1:0]  char_code;
  logic [STEP_W-1:0]  col_step;
  logic [STEP_W-1:0]  row_step;
  logic [TGT_W-1:0]   target_term;
  logic [COLOR_W-1:0] new_color;
  logic [ADDR_W-1:0]  cell_address;

  modport source (output valid, operation, char_code, col_step, row_step, target_term,
                  new_color, cell_address, input ready);
  modport sink (input valid, operation, char_code, col_step, row_step, target_term,
                new_color, cell_address, output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [OFF_W-1:0]  cursor_offset;
  logic [ACT_W-1:0]  active_terminal;
  logic              chars_written;
  logic [CELL_W-1:0] cell_value;

  modport source (output valid, cursor_col, cursor_row, cursor_offset, active_terminal,
                  chars_written, cell_value, input ready);
  modport sink (input valid, cursor_col, cursor_row, cursor_offset, active_terminal,
                chars_written, cell_value, output ready);
endinterface

// ===== hdl/tcc_screen_mem.sv =====
`timescale 1ns / 1ps

module tcc_screen_mem import tcc_pkg::*; (
  input  logic              clk,
  input  tcc_scr_req_t      req,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] cells_r [CELLS];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      cells_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= cells_r[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tcc_save_mem.sv =====
`timescale 1ns / 1ps

module tcc_save_mem import tcc_pkg::*; (
  input  logic              clk,
  input  tcc_sav_req_t      req,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] cells_r [SAVE_CELLS];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      cells_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= cells_r[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tcc_cursor_step.sv =====
`timescale 1ns / 1ps

module tcc_cursor_step import tcc_pkg::*; (
  input  logic [COL_W-1:0]  col,
  input  logic [ROW_W-1:0]  row,
  input  logic [STEP_W-1:0] dx,
  input  logic [STEP_W-1:0] dy,
  output tcc_move_t         mv
);

  localparam logic signed [9:0] W_S = 10'(SCREEN_WIDTH);
  localparam logic signed [9:0] H_S = 10'(SCREEN_HEIGHT);

  logic signed [9:0] c;
  logic signed [9:0] r;

  always_comb begin
    c = $signed({3'b000, col}) + $signed({{8{dx[1]}}, dx});
    r = $signed({5'b00000, row}) + $signed({{8{dy[1]}}, dy});
    // A column that leaves the line wraps into the neighboring row.
    if (c < 0) begin
      c = c + W_S;
      r = r - 10'sd1;
    end else if (c >= W_S) begin
      c = c - W_S;
      r = r + 10'sd1;
    end
    mv.col    = c[COL_W-1:0];
    mv.row    = row;
    mv.scroll = 1'b0;
    if (r >= 0 && r < H_S) begin
      mv.row = r[ROW_W-1:0];
    end else if (r == H_S) begin
      mv.row    = ROW_W'(SCREEN_HEIGHT - 1);
      mv.scroll = 1'b1;
    end
  end

endmodule

// ===== hdl/text_console_cursor_scroll_top.sv =====
`timescale 1ns / 1ps

// Text console engine with one shown 80x25 screen and a saved screen, cursor and color
// for each virtual terminal. After reset a clearing pass blanks both cell memories; no
// transaction is taken meanwhile. An ordinary put, move, color change or ignored switch
// goes through an execute state and a done state, and a cell read adds a read state
// between them. A move or put that scrolls runs a copy loop over the screen memory, one
// cell per cycle; a terminal switch swaps the screen against the save memory, one cell
// per cycle on each memory. A finished result sits in an output register, so the next
// transaction is accepted while it waits to be taken.
module text_console_cursor_scroll_top import tcc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  tcc_in_if.sink   in_ch,
  tcc_out_if.source out_ch
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_SWITCH = 7'b0010000,
    S_READ   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [SAV_AW-1:0] cnt_r, cnt_nxt;

  tcc_op_t            op_r, op_nxt;
  logic [CHAR_W-1:0]  ch_r, ch_nxt;
  logic [STEP_W-1:0]  dx_r, dx_nxt;
  logic [STEP_W-1:0]  dy_r, dy_nxt;
  logic [TGT_W-1:0]   tgt_r, tgt_nxt;
  logic [COLOR_W-1:0] ncolor_r, ncolor_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;

  logic [COL_W-1:0]   col_r [TERM_COUNT];
  logic [COL_W-1:0]   col_nxt [TERM_COUNT];
  logic [ROW_W-1:0]   row_r [TERM_COUNT];
  logic [ROW_W-1:0]   row_nxt [TERM_COUNT];
  logic [COLOR_W-1:0] color_r [TERM_COUNT];
  logic [COLOR_W-1:0] color_nxt [TERM_COUNT];
  logic [TERM_IW-1:0] shown_r, shown_nxt;

  logic [SAV_AW-1:0] cbase_r, cbase_nxt;
  logic [SAV_AW-1:0] tbase_r, tbase_nxt;

  // Write stage of the copy loops, which follows the read in the next cycle.
  logic              p_v_r, p_v_nxt;
  logic              p_sw_r, p_sw_nxt;
  logic              p_copy_r, p_copy_nxt;
  logic [SCR_AW-1:0] p_addr_r, p_addr_nxt;

  logic              written_r, written_nxt;
  logic [CELL_W-1:0] value_r, value_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [OFF_W-1:0]  out_off_r, out_off_nxt;
  logic [ACT_W-1:0]  out_act_r, out_act_nxt;
  logic              out_wr_r, out_wr_nxt;
  logic [CELL_W-1:0] out_val_r, out_val_nxt;

  tcc_scr_req_t      scr_req;
  tcc_sav_req_t      sav_req;
  logic [CELL_W-1:0] scr_rdata;
  logic [CELL_W-1:0] sav_rdata;

  logic [COL_W-1:0]  step_col;
  logic [STEP_W-1:0] step_dx;
  logic [STEP_W-1:0] step_dy;
  tcc_move_t         mv;
  logic              is_nl;
  logic [SCR_AW-1:0] cur_addr;

  tcc_screen_mem u_screen (
    .clk   (clk),
    .req   (scr_req),
    .rdata (scr_rdata)
  );

  tcc_save_mem u_save (
    .clk   (clk),
    .req   (sav_req),
    .rdata (sav_rdata)
  );

  tcc_cursor_step u_step (
    .col (step_col),
    .row (row_r[shown_r]),
    .dx  (step_dx),
    .dy  (step_dy),
    .mv  (mv)
  );

  assign is_nl    = (ch_r == NEWLINE_CHAR);
  assign cur_addr = SCR_AW'(col_r[shown_r]) +
                    SCR_AW'(row_r[shown_r]) * SCR_AW'(SCREEN_WIDTH);

  always_comb begin
    step_col = col_r[shown_r];
    step_dx  = dx_r;
    step_dy  = dy_r;
    if (op_r == OP_PUT) begin
      if (is_nl) begin
        step_col = '0;
        step_dx  = 2'b00;
        step_dy  = 2'b01;
      end else begin
        step_dx = 2'b01;
        step_dy = 2'b00;
      end
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    ch_nxt        = ch_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    tgt_nxt       = tgt_r;
    ncolor_nxt    = ncolor_r;
    addr_nxt      = addr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    color_nxt     = color_r;
    shown_nxt     = shown_r;
    cbase_nxt     = cbase_r;
    tbase_nxt     = tbase_r;
    p_v_nxt       = 1'b0;
    p_sw_nxt      = p_sw_r;
    p_copy_nxt    = 1'b0;
    p_addr_nxt    = cnt_r[SCR_AW-1:0];
    written_nxt   = written_r;
    value_nxt     = value_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;
    out_off_nxt   = out_off_r;
    out_act_nxt   = out_act_r;
    out_wr_nxt    = out_wr_r;
    out_val_nxt   = out_val_r;

    scr_req = '0;
    sav_req = '0;

    // Pending write of a copy loop takes the write ports first.
    if (p_v_r) begin
      scr_req.we    = 1'b1;
      scr_req.waddr = p_addr_r;
      if (p_sw_r) begin
        scr_req.wdata = sav_rdata;
        sav_req.we    = 1'b1;
        sav_req.waddr = cbase_r + SAV_AW'(p_addr_r);
        sav_req.wdata = scr_rdata;
      end else if (p_copy_r) begin
        scr_req.wdata = scr_rdata;
      end else begin
        scr_req.wdata = {color_r[shown_r], BLANK_CHAR};
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        scr_req.we    = (cnt_r < SAV_AW'(CELLS));
        scr_req.waddr = cnt_r[SCR_AW-1:0];
        scr_req.wdata = {DEFAULT_COLOR, BLANK_CHAR};
        sav_req.we    = 1'b1;
        sav_req.waddr = cnt_r;
        sav_req.wdata = {DEFAULT_COLOR, BLANK_CHAR};
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == SAV_AW'(SAVE_CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = tcc_op_t'(in_ch.operation);
          ch_nxt     = in_ch.char_code;
          dx_nxt     = in_ch.col_step;
          dy_nxt     = in_ch.row_step;
          tgt_nxt    = in_ch.target_term;
          ncolor_nxt = in_ch.new_color;
          addr_nxt   = in_ch.cell_address;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        written_nxt = 1'b0;
        value_nxt   = '0;
        cnt_nxt     = '0;
        state_nxt   = S_DONE;
        unique case (op_r)
          OP_PUT, OP_MOVE: begin
            if (op_r == OP_PUT && !is_nl) begin
              scr_req.we    = 1'b1;
              scr_req.waddr = cur_addr;
              scr_req.wdata = {color_r[shown_r], ch_r};
              written_nxt   = 1'b1;
            end
            col_nxt[shown_r] = mv.col;
            row_nxt[shown_r] = mv.row;
            if (mv.scroll) begin
              state_nxt = S_SCROLL;
            end
          end
          OP_SWITCH: begin
            if (tgt_r != TGT_W'(shown_r) && {1'b0, tgt_r} < (TGT_W + 1)'(TERM_COUNT)) begin
              cbase_nxt = SAV_AW'(shown_r) * SAV_AW'(CELLS);
              tbase_nxt = SAV_AW'(tgt_r) * SAV_AW'(CELLS);
              state_nxt = S_SWITCH;
            end
          end
          OP_SET_COLOR: begin
            color_nxt[shown_r] = ncolor_r;
          end
          OP_RESET_COLOR: begin
            color_nxt[shown_r] = DEFAULT_COLOR;
          end
          OP_READ: begin
            if (addr_r < ADDR_W'(CELLS)) begin
              scr_req.re    = 1'b1;
              scr_req.raddr = SCR_AW'(addr_r);
              state_nxt     = S_READ;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCROLL: begin
        // Rows move up by one; the bottom row gets blanks in the current color.
        p_v_nxt  = 1'b1;
        p_sw_nxt = 1'b0;
        if (cnt_r < SAV_AW'(CELLS - SCREEN_WIDTH)) begin
          scr_req.re    = 1'b1;
          scr_req.raddr = SCR_AW'(cnt_r + SAV_AW'(SCREEN_WIDTH));
          p_copy_nxt    = 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SAV_AW'(CELLS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_SWITCH: begin
        scr_req.re    = 1'b1;
        scr_req.raddr = cnt_r[SCR_AW-1:0];
        sav_req.re    = 1'b1;
        sav_req.raddr = tbase_r + cnt_r;
        p_v_nxt       = 1'b1;
        p_sw_nxt      = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == SAV_AW'(CELLS - 1)) begin
          shown_nxt = TERM_IW'(tgt_r);
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        value_nxt = scr_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = col_r[shown_r];
          out_row_nxt   = row_r[shown_r];
          out_off_nxt   = OFF_W'(col_r[shown_r]) +
                          OFF_W'(row_r[shown_r]) * OFF_W'(SCREEN_WIDTH);
          out_act_nxt   = ACT_W'(shown_r);
          out_wr_nxt    = written_r;
          out_val_nxt   = value_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      shown_r     <= '0;
      p_v_r       <= 1'b0;
      p_sw_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TERM_COUNT; i++) begin
        col_r[i]   <= '0;
        row_r[i]   <= '0;
        color_r[i] <= DEFAULT_COLOR;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      shown_r     <= shown_nxt;
      p_v_r       <= p_v_nxt;
      p_sw_r      <= p_sw_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      color_r     <= color_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ch_r      <= ch_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    tgt_r     <= tgt_nxt;
    ncolor_r  <= ncolor_nxt;
    addr_r    <= addr_nxt;
    cbase_r   <= cbase_nxt;
    tbase_r   <= tbase_nxt;
    p_copy_r  <= p_copy_nxt;
    p_addr_r  <= p_addr_nxt;
    written_r <= written_nxt;
    value_r   <= value_nxt;
    out_col_r <= out_col_nxt;
    out_row_r <= out_row_nxt;
    out_off_r <= out_off_nxt;
    out_act_r <= out_act_nxt;
    out_wr_r  <= out_wr_nxt;
    out_val_r <= out_val_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cursor_col      = out_col_r;
  assign out_ch.cursor_row      = out_row_r;
  assign out_ch.cursor_offset   = out_off_r;
  assign out_ch.active_terminal = out_act_r;
  assign out_ch.chars_written   = out_wr_r;
  assign out_ch.cell_value      = out_val_r;

endmodule

// ===== dv/tb_text_console_cursor_scroll_top.sv =====
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll_top;
  import tcc_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0]   OP_UNUSED_HI = 3'd7;
  localparam logic [STEP_W-1:0] STEP_NEG2    = 2'b10;
  localparam logic [STEP_W-1:0] STEP_NEG1    = 2'b11;
  localparam logic [STEP_W-1:0] STEP_ZERO    = 2'b00;
  localparam logic [STEP_W-1:0] STEP_POS1    = 2'b01;

  localparam int QUIET_LIMIT   = 40000;
  localparam int SCROLL_BUDGET = 300;
  localparam int RANDOM_ITEMS  = 1400;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [CHAR_W-1:0]  char_code;
    logic [STEP_W-1:0]  col_step;
    logic [STEP_W-1:0]  row_step;
    logic [TGT_W-1:0]   target_term;
    logic [COLOR_W-1:0] new_color;
    logic [ADDR_W-1:0]  cell_address;
  } console_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [OFF_W-1:0]  offset;
    logic [ACT_W-1:0]  term;
    logic              written;
    logic [CELL_W-1:0] value;
  } cursor_report_t;

  logic clk = 1'b0;
  logic rst_n;

  tcc_in_if  in_if ();
  tcc_out_if out_if ();

  text_console_cursor_scroll_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the console state.
  logic [CELL_W-1:0]  shadow_screen [CELLS];
  logic [CELL_W-1:0]  shadow_saved  [SAVE_CELLS];
  logic [COL_W-1:0]   shadow_col    [TERM_COUNT];
  logic [ROW_W-1:0]   shadow_row    [TERM_COUNT];
  logic [COLOR_W-1:0] shadow_color  [TERM_COUNT];
  logic [ACT_W-1:0]   shadow_shown;

  cursor_report_t pending_reports[$];
  int mismatches = 0;
  int hold_cycles = 0;
  bit calm = 1'b0;

  function automatic void clear_shadow();
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = {DEFAULT_COLOR, BLANK_CHAR};
    for (int i = 0; i < SAVE_CELLS; i++) shadow_saved[i] = {DEFAULT_COLOR, BLANK_CHAR};
    for (int i = 0; i < TERM_COUNT; i++) begin
      shadow_col[i]   = '0;
      shadow_row[i]   = '0;
      shadow_color[i] = DEFAULT_COLOR;
    end
    shadow_shown = '0;
  endfunction

  // Column wrap carries into the row; the row is then judged by the caller.
  function automatic void wrap_step(input int col, input int row, input int dx, input int dy,
                                    output int ncol, output int nrow);
    ncol = col + dx;
    nrow = row + dy;
    if (ncol < 0) begin
      nrow--;
      ncol += SCREEN_WIDTH;
    end else if (ncol >= SCREEN_WIDTH) begin
      nrow++;
      ncol -= SCREEN_WIDTH;
    end
  endfunction

  function automatic void shift_cursor(int dx, int dy);
    int t;
    int ncol;
    int nrow;
    t = int'(shadow_shown);
    wrap_step(int'(shadow_col[t]), int'(shadow_row[t]), dx, dy, ncol, nrow);
    shadow_col[t] = COL_W'(ncol);
    if (nrow >= 0 && nrow < SCREEN_HEIGHT) begin
      shadow_row[t] = ROW_W'(nrow);
    end else if (nrow == SCREEN_HEIGHT) begin
      shadow_row[t] = ROW_W'(SCREEN_HEIGHT - 1);
      for (int i = 0; i < CELLS - SCREEN_WIDTH; i++)
        shadow_screen[i] = shadow_screen[i + SCREEN_WIDTH];
      for (int i = CELLS - SCREEN_WIDTH; i < CELLS; i++)
        shadow_screen[i] = {shadow_color[t], BLANK_CHAR};
    end
  endfunction

  function automatic cursor_report_t apply_console_op(console_cmd_t c);
    cursor_report_t r;
    int t;
    int tgt;
    int idx;
    r = '0;
    t = int'(shadow_shown);
    case (c.operation)
      OP_PUT: begin
        if (c.char_code == NEWLINE_CHAR) begin
          shadow_col[t] = '0;
          shift_cursor(0, 1);
        end else begin
          idx = int'(shadow_col[t]) + int'(shadow_row[t]) * SCREEN_WIDTH;
          if (idx < CELLS) shadow_screen[idx] = {shadow_color[t], c.char_code};
          r.written = 1'b1;
          shift_cursor(1, 0);
        end
      end
      OP_MOVE: shift_cursor(int'($signed(c.col_step)), int'($signed(c.row_step)));
      OP_SWITCH: begin
        tgt = int'(c.target_term);
        if (tgt != t && tgt < TERM_COUNT) begin
          for (int i = 0; i < CELLS; i++) shadow_saved[t * CELLS + i] = shadow_screen[i];
          shadow_shown = ACT_W'(tgt);
          for (int i = 0; i < CELLS; i++) shadow_screen[i] = shadow_saved[tgt * CELLS + i];
        end
      end
      OP_SET_COLOR:   shadow_color[t] = c.new_color;
      OP_RESET_COLOR: shadow_color[t] = DEFAULT_COLOR;
      OP_READ: begin
        if (int'(c.cell_address) < CELLS) r.value = shadow_screen[int'(c.cell_address)];
      end
      default: ;
    endcase
    t = int'(shadow_shown);
    r.col    = shadow_col[t];
    r.row    = shadow_row[t];
    r.offset = OFF_W'(int'(shadow_col[t]) + int'(shadow_row[t]) * SCREEN_WIDTH);
    r.term   = shadow_shown;
    return r;
  endfunction

  // True when the command would run one of the long copy loops (scroll or switch).
  function automatic bit is_copy_heavy(console_cmd_t c);
    int t;
    int ncol;
    int nrow;
    t = int'(shadow_shown);
    nrow = 0;
    case (c.operation)
      OP_PUT: begin
        if (c.char_code == NEWLINE_CHAR)
          wrap_step(0, int'(shadow_row[t]), 0, 1, ncol, nrow);
        else
          wrap_step(int'(shadow_col[t]), int'(shadow_row[t]), 1, 0, ncol, nrow);
      end
      OP_MOVE: wrap_step(int'(shadow_col[t]), int'(shadow_row[t]),
                         int'($signed(c.col_step)), int'($signed(c.row_step)), ncol, nrow);
      OP_SWITCH: return int'(c.target_term) != t && int'(c.target_term) < TERM_COUNT;
      default: return 1'b0;
    endcase
    return nrow == SCREEN_HEIGHT;
  endfunction

  // Fields that the operation does not use are left random.
  function automatic console_cmd_t build_cmd(logic [OP_W-1:0] op, int unsigned arg);
    console_cmd_t c;
    c.operation    = op;
    c.char_code    = CHAR_W'($urandom_range(0, 255));
    c.col_step     = STEP_W'($urandom_range(0, 3));
    c.row_step     = STEP_W'($urandom_range(0, 3));
    c.target_term  = TGT_W'($urandom_range(0, 15));
    c.new_color    = COLOR_W'($urandom_range(0, 255));
    c.cell_address = ADDR_W'($urandom_range(0, 2047));
    case (op)
      OP_PUT:       c.char_code = CHAR_W'(arg);
      OP_MOVE:      {c.col_step, c.row_step} = (2 * STEP_W)'(arg);
      OP_SWITCH:    c.target_term = TGT_W'(arg);
      OP_SET_COLOR: c.new_color = COLOR_W'(arg);
      OP_READ:      c.cell_address = ADDR_W'(arg);
      default: ;
    endcase
    return c;
  endfunction

  function automatic console_cmd_t random_cmd();
    int pick;
    logic [STEP_W-1:0] dy;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      if ($urandom_range(0, 9) == 0) return build_cmd(OP_PUT, NEWLINE_CHAR);
      return build_cmd(OP_PUT, $urandom_range(0, 255));
    end
    if (pick < 75) begin
      // Lean downward so the cursor reaches the bottom row and scrolls.
      dy = $urandom_range(0, 1) ? STEP_POS1 : STEP_W'($urandom_range(0, 3));
      return build_cmd(OP_MOVE, {STEP_W'($urandom_range(0, 3)), dy});
    end
    if (pick < 79)
      return build_cmd(OP_SWITCH, $urandom_range(0, 1) ? $urandom_range(0, TERM_COUNT - 1)
                                                      : $urandom_range(0, 15));
    if (pick < 85) return build_cmd(OP_SET_COLOR, $urandom_range(0, 255));
    if (pick < 88) return build_cmd(OP_RESET_COLOR, 0);
    if (pick < 98)
      return build_cmd(OP_READ, ($urandom_range(0, 19) == 0) ? $urandom_range(CELLS, 2047)
                                                             : $urandom_range(0, CELLS - 1));
    return build_cmd($urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO, 0);
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_cmd(console_cmd_t c);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.operation    <= c.operation;
    in_if.char_code    <= c.char_code;
    in_if.col_step     <= c.col_step;
    in_if.row_step     <= c.row_step;
    in_if.target_term  <= c.target_term;
    in_if.new_color    <= c.new_color;
    in_if.cell_address <= c.cell_address;
    do @(posedge clk); while (!in_if.ready);
    pending_reports.push_back(apply_console_op(c));
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_cmd(build_cmd(OP_PUT, 8'h00));
    send_cmd(build_cmd(OP_SET_COLOR, 8'hFF));
    send_cmd(build_cmd(OP_PUT, 8'hFF));
    send_cmd(build_cmd(OP_SET_COLOR, 8'h00));
    send_cmd(build_cmd(OP_PUT, 8'h41));
    send_cmd(build_cmd(OP_RESET_COLOR, 0));
    send_cmd(build_cmd(OP_MOVE, {STEP_NEG1, STEP_ZERO}));
    send_cmd(build_cmd(OP_MOVE, {STEP_NEG2, STEP_ZERO}));
    // Wrapping left off the top row keeps the row but still wraps the column.
    send_cmd(build_cmd(OP_MOVE, {STEP_NEG2, STEP_ZERO}));
    send_cmd(build_cmd(OP_MOVE, {STEP_POS1, STEP_ZERO}));
    send_cmd(build_cmd(OP_PUT, 8'h7E));
    send_cmd(build_cmd(OP_MOVE, {STEP_ZERO, STEP_NEG2}));
    send_cmd(build_cmd(OP_MOVE, {STEP_NEG1, STEP_POS1}));
    send_cmd(build_cmd(OP_PUT, NEWLINE_CHAR));
    send_cmd(build_cmd(OP_READ, 0));
    send_cmd(build_cmd(OP_READ, 1));
    send_cmd(build_cmd(OP_READ, CELLS - 1));
    send_cmd(build_cmd(OP_READ, CELLS));
    send_cmd(build_cmd(OP_READ, 2047));
    send_cmd(build_cmd(OP_SWITCH, 0));
    send_cmd(build_cmd(OP_SWITCH, 15));
    send_cmd(build_cmd(OP_SWITCH, TERM_COUNT));
    send_cmd(build_cmd(OP_SWITCH, TERM_COUNT - 1));
    send_cmd(build_cmd(OP_PUT, 8'h55));
    send_cmd(build_cmd(OP_READ, 1));
    send_cmd(build_cmd(OP_SWITCH, 0));
    send_cmd(build_cmd(OP_READ, 1));
    send_cmd(build_cmd(OP_UNUSED_LO, 0));
    send_cmd(build_cmd(OP_UNUSED_HI, 0));
    wait_drain();
  endtask

  // The receiver stops long enough for the block to back up into its input.
  task automatic test_output_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 24; i++) send_cmd(random_cmd());
    wait_drain();
  endtask

  task automatic test_random_traffic();
    console_cmd_t c;
    int copies_used;
    copies_used = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 600 && i < 900);
      c = random_cmd();
      if (is_copy_heavy(c)) begin
        if (copies_used >= SCROLL_BUDGET)
          c = build_cmd(OP_READ, $urandom_range(0, CELLS - 1));
        else
          copies_used++;
      end
      send_cmd(c);
    end
    calm = 1'b0;
    wait_drain();
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.col     = out_if.cursor_col;
      got.row     = out_if.cursor_row;
      got.offset  = out_if.cursor_offset;
      got.term    = out_if.active_terminal;
      got.written = out_if.chars_written;
      got.value   = out_if.cell_value;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: col %0d row %0d off %0d term %0d wr %0b cell %h",
                   got.col, got.row, got.offset, got.term, got.written, got.value);
      end else begin
        want = pending_reports.pop_front();
        if (got.col !== want.col || got.row !== want.row || got.offset !== want.offset ||
            got.term !== want.term || got.written !== want.written ||
            got.value !== want.value) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("expected: col %0d row %0d off %0d term %0d wr %0b cell %h",
                     want.col, want.row, want.offset, want.term, want.written, want.value);
            $display("actual:   col %0d row %0d off %0d term %0d wr %0b cell %h",
                     got.col, got.row, got.offset, got.term, got.written, got.value);
          end
        end
      end
    end
  end

  // Ends the run when no transaction moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("text_console_cursor_scroll_top: mismatch");
    $finish;
  end

  initial begin
    clear_shadow();
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.operation    <= OP_PUT;
    in_if.char_code    <= '0;
    in_if.col_step     <= '0;
    in_if.row_step     <= '0;
    in_if.target_term  <= '0;
    in_if.new_color    <= '0;
    in_if.cell_address <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_output_backpressure();
    test_random_traffic();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0)
      $display("text_console_cursor_scroll_top: match");
    else
      $display("text_console_cursor_scroll_top: mismatch");
    $finish;
  end

endmodule
